// ----- src/tscf_pkg.sv -----
// ----------------------------------------------------------------------------
// tscf_pkg
// shared types and constants of the text stream filter: register indexes,
// character codes and the job record passed from front to back
// ----------------------------------------------------------------------------
package tscf_pkg;

  // configuration register indexes
  localparam int unsigned CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] REG_NUMBER_NONBLANK  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_NUMBER_ALL       = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SHOW_ENDS        = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SHOW_TABS        = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SHOW_NONPRINTING = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_SQUEEZE_BLANK    = 3'd5;

  // character codes
  localparam logic [7:0] CHAR_TAB    = 8'd9;
  localparam logic [7:0] CHAR_NL     = 8'd10;
  localparam logic [7:0] CHAR_SPACE  = 8'd32;
  localparam logic [7:0] CHAR_DOLLAR = 8'd36;
  localparam logic [7:0] CHAR_DASH   = 8'd45;
  localparam logic [7:0] CHAR_ZERO   = 8'd48;
  localparam logic [7:0] CHAR_QUERY  = 8'd63;
  localparam logic [7:0] CHAR_I      = 8'd73;
  localparam logic [7:0] CHAR_M      = 8'd77;
  localparam logic [7:0] CHAR_CARET  = 8'd94;

  // byte class boundaries for caret and meta notation
  localparam logic [7:0] CTRL_LIMIT  = 8'd32;
  localparam logic [7:0] CTRL_OFFSET = 8'd64;
  localparam logic [7:0] CHAR_DEL    = 8'd127;
  localparam logic [7:0] META_BASE   = 8'd128;
  localparam logic [7:0] META_PRINT  = 8'd160;
  localparam logic [7:0] META_DEL    = 8'd255;

  // line number field
  localparam logic [3:0] DEC_MAX_DIGIT = 4'd9;
  localparam int unsigned PAD_WIDTH    = 6;

  // queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // most bytes of text an item expands to, after any line number
  localparam int unsigned BODY_MAX = 4;

  typedef struct packed {
    logic                     numbered;
    logic [2:0]               body_len;
    logic [BODY_MAX-1:0][7:0] body;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

// ----- src/tscf_item_if.sv -----
// ----------------------------------------------------------------------------
// tscf_item_if
// input channel: one raw text byte per request with a start-of-file mark
// ----------------------------------------------------------------------------
interface tscf_item_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       file_start;

  modport source (output valid, data_byte, file_start, input ready);
  modport sink (input valid, data_byte, file_start, output ready);
endinterface

// ----- src/tscf_result_if.sv -----
// ----------------------------------------------------------------------------
// tscf_result_if
// output channel: one output character per request, last marks end of run
// ----------------------------------------------------------------------------
interface tscf_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;

  modport source (output valid, out_byte, last_of_run, input ready);
  modport sink (input valid, out_byte, last_of_run, output ready);
endinterface

// ----- src/tscf_cfg_if.sv -----
// ----------------------------------------------------------------------------
// tscf_cfg_if
// configuration write channel: register index and write data
// ----------------------------------------------------------------------------
interface tscf_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [tscf_pkg::CFG_INDEX_W-1:0]   index;
  logic                               wdata;

  modport source (output valid, index, wdata, input ready);
  modport sink (input valid, index, wdata, output ready);
endinterface

// ----- src/tscf_front.sv -----
// ----------------------------------------------------------------------------
// tscf_front
// accepts text bytes, tracks line state and the decimal line count, and
// turns each byte that is not squeezed away into a job for the output sequencer
// ----------------------------------------------------------------------------
module tscf_front #(
  parameter int unsigned NUMBER_DIGITS = 7
) (
  input  logic                          clk,
  input  logic                          rst,
  tscf_item_if.sink                     item,
  tscf_cfg_if.sink                      cfg,
  output tscf_pkg::job_t                job,
  output logic [NUMBER_DIGITS-1:0][3:0] job_digits,
  output logic                          push,
  input  logic                          queue_full
);

  logic number_nonblank;
  logic number_all;
  logic show_ends;
  logic show_tabs;
  logic show_nonprinting;
  logic squeeze_blank;

  logic [NUMBER_DIGITS-1:0][3:0] digits;
  logic                          prev_nl;
  logic                          squeezing;

  logic [7:0]                    ch;
  logic                          is_nl;
  logic                          start_prev_nl;
  logic                          start_squeezing;
  logic [NUMBER_DIGITS-1:0][3:0] start_digits;
  logic [NUMBER_DIGITS-1:0][3:0] inc_digits;
  logic [NUMBER_DIGITS-1:0][3:0] digits_next;
  logic                          all_nine;
  logic                          carry;
  logic                          blank_repeat;
  logic                          drop;
  logic                          numbered;
  logic                          accept;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      number_nonblank  <= 1'b0;
      number_all       <= 1'b0;
      show_ends        <= 1'b0;
      show_tabs        <= 1'b0;
      show_nonprinting <= 1'b0;
      squeeze_blank    <= 1'b0;
    end else if (cfg.valid) begin
      case (cfg.index)
        tscf_pkg::REG_NUMBER_NONBLANK:  number_nonblank  <= cfg.wdata;
        tscf_pkg::REG_NUMBER_ALL:       number_all       <= cfg.wdata;
        tscf_pkg::REG_SHOW_ENDS:        show_ends        <= cfg.wdata;
        tscf_pkg::REG_SHOW_TABS:        show_tabs        <= cfg.wdata;
        tscf_pkg::REG_SHOW_NONPRINTING: show_nonprinting <= cfg.wdata;
        tscf_pkg::REG_SQUEEZE_BLANK:    squeeze_blank    <= cfg.wdata;
        default: ;
      endcase
    end
  end

  // per-file state as seen by this byte
  always_comb begin
    ch              = item.data_byte;
    is_nl           = (ch == tscf_pkg::CHAR_NL);
    start_prev_nl   = item.file_start | prev_nl;
    start_squeezing = !item.file_start & squeezing;
    start_digits    = item.file_start ? '0 : digits;
    blank_repeat    = squeeze_blank & is_nl & start_prev_nl;
    drop            = blank_repeat & start_squeezing;
    numbered        = start_prev_nl & (number_nonblank ? !is_nl : number_all);
  end

  // decimal increment, holding at all nines
  always_comb begin
    carry    = 1'b1;
    all_nine = 1'b1;
    for (int i = 0; i < NUMBER_DIGITS; i++) begin
      if (start_digits[i] != tscf_pkg::DEC_MAX_DIGIT) all_nine = 1'b0;
      if (carry) begin
        if (start_digits[i] == tscf_pkg::DEC_MAX_DIGIT) begin
          inc_digits[i] = 4'd0;
        end else begin
          inc_digits[i] = start_digits[i] + 4'd1;
          carry         = 1'b0;
        end
      end else begin
        inc_digits[i] = start_digits[i];
      end
    end
    if (!numbered) begin
      digits_next = start_digits;
    end else if (all_nine) begin
      digits_next = start_digits;
    end else begin
      digits_next = inc_digits;
    end
  end

  // text that follows any line number
  always_comb begin
    job.numbered = numbered;
    job.body     = '0;
    job.body_len = 3'd1;
    job.body[0]  = ch;
    if (is_nl && show_ends) begin
      job.body[0]  = tscf_pkg::CHAR_DOLLAR;
      job.body[1]  = tscf_pkg::CHAR_NL;
      job.body_len = 3'd2;
    end else if (is_nl) begin
      job.body_len = 3'd1;
    end else if (ch == tscf_pkg::CHAR_TAB && show_tabs) begin
      job.body[0]  = tscf_pkg::CHAR_CARET;
      job.body[1]  = tscf_pkg::CHAR_I;
      job.body_len = 3'd2;
    end else if (show_nonprinting && ch < tscf_pkg::CTRL_LIMIT &&
                 ch != tscf_pkg::CHAR_TAB) begin
      job.body[0]  = tscf_pkg::CHAR_CARET;
      job.body[1]  = ch + tscf_pkg::CTRL_OFFSET;
      job.body_len = 3'd2;
    end else if (show_nonprinting && ch == tscf_pkg::CHAR_DEL) begin
      job.body[0]  = tscf_pkg::CHAR_CARET;
      job.body[1]  = tscf_pkg::CHAR_QUERY;
      job.body_len = 3'd2;
    end else if (show_nonprinting && ch >= tscf_pkg::META_BASE) begin
      job.body[0] = tscf_pkg::CHAR_M;
      job.body[1] = tscf_pkg::CHAR_DASH;
      if (ch < tscf_pkg::META_PRINT) begin
        job.body[2]  = tscf_pkg::CHAR_CARET;
        job.body[3]  = ch - tscf_pkg::CTRL_OFFSET;
        job.body_len = 3'd4;
      end else if (ch == tscf_pkg::META_DEL) begin
        job.body[2]  = tscf_pkg::CHAR_CARET;
        job.body[3]  = tscf_pkg::CHAR_QUERY;
        job.body_len = 3'd4;
      end else begin
        job.body[2]  = ch - tscf_pkg::META_BASE;
        job.body_len = 3'd3;
      end
    end
  end

  assign job_digits = digits_next;
  assign item.ready = !queue_full;
  assign accept     = item.valid & !queue_full;
  assign push       = accept & !drop;

  // a dropped newline never carries a file start, so it changes no state
  always_ff @(posedge clk) begin
    if (rst) begin
      digits    <= '0;
      prev_nl   <= 1'b1;
      squeezing <= 1'b0;
    end else if (push) begin
      digits    <= digits_next;
      prev_nl   <= is_nl;
      squeezing <= blank_repeat;
    end
  end

endmodule

// ----- src/tscf_queue.sv -----
// ----------------------------------------------------------------------------
// tscf_queue
// short first-in first-out queue of jobs between front and back
// ----------------------------------------------------------------------------
module tscf_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  logic [WIDTH-1:0]        push_data,
  input  logic                    pop,
  output logic [WIDTH-1:0]        head,
  output tscf_pkg::queue_status_t status
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign status.full  = (count == CW'(DEPTH));
  assign status.empty = (count == '0);
  assign head         = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// ----- src/tscf_back.sv -----
// ----------------------------------------------------------------------------
// tscf_back
// output sequencer: walks the head job one character per cycle, while the
// result is taken, into the registered output stage
// ----------------------------------------------------------------------------
module tscf_back #(
  parameter int unsigned NUMBER_DIGITS = 7
) (
  input  logic                          clk,
  input  logic                          rst,
  input  tscf_pkg::job_t                job,
  input  logic [NUMBER_DIGITS-1:0][3:0] digits,
  input  logic                          queue_empty,
  output logic                          pop,
  output logic                          busy,
  tscf_result_if.source                 result
);

  localparam int unsigned CW  = $clog2(NUMBER_DIGITS + 1);
  localparam int unsigned PW  = $clog2(NUMBER_DIGITS + 6);
  localparam int unsigned BIW = $clog2(tscf_pkg::BODY_MAX);

  logic [PW-1:0] pos;
  logic [CW-1:0] nd;
  logic [CW-1:0] field_w;
  logic [PW-1:0] num_len;
  logic [PW-1:0] total;
  logic [PW-1:0] col;
  logic [PW-1:0] body_idx;
  logic [7:0]    char_sel;
  logic          last;
  logic          take;
  logic          emit;

  // significant digits and padded field width
  always_comb begin
    nd = CW'(1);
    for (int i = 1; i < NUMBER_DIGITS; i++) begin
      if (digits[i] != 4'd0) nd = CW'(i + 1);
    end
    field_w = (nd > CW'(tscf_pkg::PAD_WIDTH)) ? nd : CW'(tscf_pkg::PAD_WIDTH);
    num_len = job.numbered ? PW'(field_w) + PW'(1) : '0;
    total   = num_len + PW'(job.body_len);
    last    = (pos == total - PW'(1));
  end

  // character at the current position
  always_comb begin
    col      = PW'(field_w) - PW'(1) - pos;
    body_idx = pos - num_len;
    char_sel = job.body[body_idx[BIW-1:0]];
    if (pos < num_len) begin
      if (pos == PW'(field_w)) begin
        char_sel = tscf_pkg::CHAR_TAB;
      end else begin
        char_sel = tscf_pkg::CHAR_SPACE;
        for (int i = 0; i < NUMBER_DIGITS; i++) begin
          if (col == PW'(i) && PW'(i) < PW'(nd)) begin
            char_sel = tscf_pkg::CHAR_ZERO + {4'd0, digits[i]};
          end
        end
      end
    end
  end

  assign take = !result.valid | result.ready;
  assign emit = take & !queue_empty;
  assign pop  = emit & last;
  assign busy = (pos != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
      pos          <= '0;
    end else if (emit) begin
      result.valid <= 1'b1;
      pos          <= last ? '0 : pos + PW'(1);
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result.out_byte    <= char_sel;
      result.last_of_run <= last;
    end
  end

endmodule

// ----- src/text_stream_cat_filter.sv -----
// ----------------------------------------------------------------------------
// text_stream_cat_filter
// cat-style text filter: line numbering, blank line squeezing, end marks,
// tab and control character display
// ----------------------------------------------------------------------------
// One text byte enters per request and produces one to twelve output
// characters (none for a squeezed blank line), the last of them flagged with
// last_of_run. The output port moves one character per cycle while the
// result is taken, and an item that expands to n characters holds the output
// sequencer until all n have gone out; inputs keep flowing into a two-entry
// job queue in the meantime and stall only when it is full. The first
// character of an accepted byte goes through the job queue into the output
// register, from which it can be taken. Line numbers are kept as a decimal
// counter of NUMBER_DIGITS digits, saturating at all nines, printed right
// aligned in a field of at least six characters and followed by a tab. There
// is no clearing pass after reset. Configuration writes complete at once and
// should only be issued while the filter is idle.
// ----------------------------------------------------------------------------
module text_stream_cat_filter #(
  parameter int unsigned NUMBER_DIGITS = 7
) (
  input  logic          clk,
  input  logic          rst,
  tscf_item_if.sink     item,
  tscf_result_if.source result,
  tscf_cfg_if.sink      cfg
);

  // queue entry carries the job record and the decimal line number
  localparam int unsigned QW = $bits(tscf_pkg::job_t) + NUMBER_DIGITS * 4;

  tscf_pkg::job_t                job;
  logic [NUMBER_DIGITS-1:0][3:0] job_digits;
  logic                          q_push;
  logic                          q_pop;
  logic [QW-1:0]                 q_head;
  tscf_pkg::queue_status_t       q_status;
  tscf_pkg::job_t                head_job;
  logic [NUMBER_DIGITS-1:0][3:0] head_digits;
  logic                          back_busy;

  // front: takes requests, applies squeeze and numbering decisions
  tscf_front #(
    .NUMBER_DIGITS(NUMBER_DIGITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .cfg        (cfg),
    .job        (job),
    .job_digits (job_digits),
    .push       (q_push),
    .queue_full (q_status.full)
  );

  // decouples intake from the output, which moves one character per cycle unless stalled
  tscf_queue #(
    .WIDTH(QW),
    .DEPTH(tscf_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data ({job_digits, job}),
    .pop       (q_pop),
    .head      (q_head),
    .status    (q_status)
  );

  assign {head_digits, head_job} = q_head;

  // back: expands the head job into output characters
  tscf_back #(
    .NUMBER_DIGITS(NUMBER_DIGITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .job         (head_job),
    .digits      (head_digits),
    .queue_empty (q_status.empty),
    .pop         (q_pop),
    .busy        (back_busy),
    .result      (result)
  );

  // no job is written into a full queue
  a_no_overflow : assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_status.full)
    else $error("job pushed into full queue");

  // retiring a job always leaves its final character in the output stage
  a_pop_marks_last : assert property (@(posedge clk) disable iff (rst)
    q_pop |=> (result.valid && result.last_of_run))
    else $error("job retired without a last character");

  // a job part way through expansion is still at the head of the queue
  a_busy_has_job : assert property (@(posedge clk) disable iff (rst)
    back_busy |-> !q_status.empty)
    else $error("sequencer mid-job with empty queue");

endmodule
